[hdl/nsdq_pkg.sv]
package nsdq_pkg;

    // default build parameters
    localparam int DEF_FILTER_TAPS   = 4;
    localparam int DEF_CHANNEL_COUNT = 2;
    localparam int DEF_FRACTION_BITS = 12;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 16;
    localparam int GAIN_W   = 15;
    localparam int HIST_W   = 24;
    localparam int LCG_W    = 32;
    localparam int MUL_W    = 33;

    // shaping filter length that carries non-zero coefficients
    localparam int COEF_COUNT = 4;

    // output code limits
    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAG = 32768;

    // filter output history limits (24-bit signed)
    localparam longint HIST_MAX = 8388607;
    localparam longint HIST_MIN = -8388608;

    // register and generator constants
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd32753;
    localparam logic [LCG_W-1:0]  LCG_SEED   = 32'd22222;
    localparam logic [LCG_W-1:0]  LCG_MUL    = 32'd96314165;
    localparam logic [LCG_W-1:0]  LCG_INC    = 32'd907633515;

    // shaping coefficient in q.fbits, rounded half away from zero
    // indices 0..3 are the error taps, 4..7 the output taps
    function automatic longint coef_q(input int idx, input int fbits);
        longint c;
        longint m;
        longint q;
        case (idx)
            0:       c = 22061;
            1:       c = -4706;
            2:       c = -2534;
            3:       c = -6214;
            4:       c = 10587;
            5:       c = 676;
            6:       c = -6054;
            7:       c = -2738;
            default: c = 0;
        endcase
        m = ((c < 0) ? -c : c) * (longint'(1) << fbits);
        q = (m * 2 + 10000) / 20000;
        return (c < 0) ? -q : q;
    endfunction

endpackage

[hdl/nsdq_if.sv]
// input frame channel
interface nsdq_in_if import nsdq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_end, output ready);
endinterface

// output frame channel
interface nsdq_out_if import nsdq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    clipped;
    logic                    last_out;

    modport source (output valid, output left_out, output right_out,
                    output clipped, output last_out, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input clipped, input last_out, output ready);
endinterface

// gain register write channel
interface nsdq_cfg_if import nsdq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/nsdq_mul.sv]
module nsdq_mul import nsdq_pkg::*; #(
    parameter int PROD_W = 40
) (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [2*MUL_W-1:0] w_full;
    logic signed [PROD_W-1:0]  r_prod;

    // full signed product, low part kept
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

[hdl/noise_shaped_dither_quantizer.sv]
// Requantizes one stereo frame of 24-bit samples to two 16-bit samples with error-feedback
// noise shaping and triangular dither, left channel first. Every product (gain, filter
// taps and the dither generator) goes through one registered multiplier under a small
// sequencer, so a new frame is accepted only once the last one is through the sequencer;
// the result waits in an output register, and a new frame may be accepted while it does.
// The input is not ready while a frame is in work or while reset is held. Gain writes are
// taken whenever reset is released and must come only while the block is idle.
module noise_shaped_dither_quantizer import nsdq_pkg::*; #(
    parameter int FILTER_TAPS   = DEF_FILTER_TAPS,
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nsdq_cfg_if.sink  i_cfg,
    nsdq_in_if.sink   i_in,
    nsdq_out_if.source o_out
);

    localparam int F      = FRACTION_BITS;
    localparam int SW     = F + 16;
    localparam int VW     = F + 18;
    localparam int EW     = F + 2;
    localparam int CW     = F + 3;
    localparam int AW     = F + 31;
    localparam int DW     = F + 1;
    localparam int MAGW   = VW - F;
    localparam int PROD_W = (F + 26 > 39) ? (F + 26) : 39;
    localparam int TAPW   = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam longint HALF = longint'(1) << (F - 1);
    localparam longint LIM  = 3 * HALF;

    localparam longint COEF_E [COEF_COUNT] = '{
        coef_q(0, F), coef_q(1, F), coef_q(2, F), coef_q(3, F)
    };
    localparam longint COEF_O [COEF_COUNT] = '{
        coef_q(4, F), coef_q(5, F), coef_q(6, F), coef_q(7, F)
    };

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LCG1  = 12'b0000_0000_0010,
        S_GAIN  = 12'b0000_0000_0100,
        S_LCG2  = 12'b0000_0000_1000,
        S_TAP_E = 12'b0000_0001_0000,
        S_TAP_F = 12'b0000_0010_0000,
        S_WAIT  = 12'b0000_0100_0000,
        S_ERR   = 12'b0000_1000_0000,
        S_SUB   = 12'b0001_0000_0000,
        S_ROUND = 12'b0010_0000_0000,
        S_STORE = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    // what the product register holds this cycle
    typedef enum logic [2:0] {
        K_NONE,
        K_LCG1,
        K_GAIN,
        K_LCG2,
        K_TAP_E,
        K_TAP_F
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic              r_ch;
    logic [TAPW-1:0]   r_tap;
    logic [GAIN_W-1:0] r_gain;
    logic [LCG_W-1:0]  r_lcg;
    logic [LCG_W-1:0]  r_u1;

    logic signed [HIST_W-1:0] r_fh [CHANNEL_COUNT][FILTER_TAPS];
    logic signed [EW-1:0]     r_eh [CHANNEL_COUNT][FILTER_TAPS];

    logic signed [SAMPLE_W-1:0] r_left, r_right;
    logic                       r_last;
    logic signed [SW-1:0]       r_s;
    logic signed [AW-1:0]       r_acc;
    logic signed [DW-1:0]       r_dith;
    logic signed [HIST_W-1:0]   r_err;
    logic signed [VW-1:0]       r_sr, r_sp, r_v;
    logic signed [OUT_W-1:0]    r_y, r_yl, r_yr;
    logic                       r_clip;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_left, r_out_right;
    logic                    r_out_clip, r_out_last;

    logic                       w_ch_idx;
    logic                       w_in_take;
    logic                       w_out_free;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic signed [CW-1:0]       w_coef_e, w_coef_o;
    logic signed [MUL_W-1:0]    w_ma, w_mb;
    logic signed [PROD_W-1:0]   w_prod;
    logic [LCG_W-1:0]           w_lcg_next;
    logic signed [LCG_W:0]      w_ud;
    logic signed [AW-1:0]       w_acc_r, w_err_full;
    logic signed [HIST_W-1:0]   w_err;
    logic                       w_neg;
    logic [VW-1:0]              w_magp;
    logic [MAGW-1:0]            w_mag;
    logic signed [OUT_W-1:0]    w_y;
    logic                       w_sat;
    logic signed [VW-1:0]       w_e_full;
    logic signed [EW-1:0]       w_e;

    // handshakes
    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign w_in_take   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;
    assign o_out.clipped   = r_out_clip;
    assign o_out.last_out  = r_out_last;

    // current channel and its sample
    assign w_ch_idx = (CHANNEL_COUNT > 1) ? r_ch : 1'b0;
    assign w_sample = (r_ch == 1'b0) ? r_left : r_right;

    // coefficient lookup, taps past the fourth are zero
    always_comb begin
        w_coef_e = '0;
        w_coef_o = '0;
        for (int k = 0; k < COEF_COUNT; k++) begin
            if (int'(r_tap) == k) begin
                w_coef_e = CW'(COEF_E[k]);
                w_coef_o = CW'(COEF_O[k]);
            end
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        n_kind = K_NONE;
        case (r_state)
            S_LCG1: begin
                w_ma   = MUL_W'({1'b0, r_lcg});
                w_mb   = MUL_W'({1'b0, LCG_MUL});
                n_kind = K_LCG1;
            end
            S_GAIN: begin
                w_ma   = MUL_W'(w_sample);
                w_mb   = MUL_W'({1'b0, r_gain});
                n_kind = K_GAIN;
            end
            S_LCG2: begin
                w_ma   = MUL_W'({1'b0, r_lcg});
                w_mb   = MUL_W'({1'b0, LCG_MUL});
                n_kind = K_LCG2;
            end
            S_TAP_E: begin
                w_ma   = MUL_W'(r_eh[w_ch_idx][r_tap]);
                w_mb   = MUL_W'(w_coef_e);
                n_kind = K_TAP_E;
            end
            S_TAP_F: begin
                w_ma   = MUL_W'(r_fh[w_ch_idx][r_tap]);
                w_mb   = MUL_W'(w_coef_o);
                n_kind = K_TAP_F;
            end
            default: begin
                w_ma   = '0;
                w_mb   = '0;
                n_kind = K_NONE;
            end
        endcase
    end

    nsdq_mul #(
        .PROD_W (PROD_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // generator step from the product
    assign w_lcg_next = w_prod[LCG_W-1:0] + LCG_INC;

    // triangular dither from the two draws
    assign w_ud = $signed({1'b0, r_u1}) - $signed({1'b0, r_lcg});

    // filter output, rounded half up and saturated to 24 bits
    assign w_acc_r    = r_acc + AW'(HALF);
    assign w_err_full = w_acc_r >>> F;
    always_comb begin
        if (w_err_full > AW'(HIST_MAX)) begin
            w_err = HIST_W'(HIST_MAX);
        end else if (w_err_full < AW'(HIST_MIN)) begin
            w_err = HIST_W'(HIST_MIN);
        end else begin
            w_err = w_err_full[HIST_W-1:0];
        end
    end

    // round half away from zero and saturate to 16 bits
    assign w_neg  = r_v[VW-1];
    assign w_magp = w_neg ? (VW'(HALF) - r_v) : (r_v + VW'(HALF));
    assign w_mag  = w_magp[VW-1:F];
    always_comb begin
        w_sat = 1'b0;
        if (!w_neg && (w_mag > MAGW'(OUT_POS_MAX))) begin
            w_y   = OUT_W'(OUT_POS_MAX);
            w_sat = 1'b1;
        end else if (w_neg && (w_mag > MAGW'(OUT_NEG_MAG))) begin
            w_y   = -OUT_W'(OUT_NEG_MAG);
            w_sat = 1'b1;
        end else if (w_neg) begin
            w_y = -OUT_W'(w_mag);
        end else begin
            w_y = OUT_W'(w_mag);
        end
    end

    // rounding error, clamped to one and a half steps
    assign w_e_full = (VW'(r_y) <<< F) - r_sp;
    always_comb begin
        if (w_e_full > VW'(LIM)) begin
            w_e = EW'(LIM);
        end else if (w_e_full < -VW'(LIM)) begin
            w_e = -EW'(LIM);
        end else begin
            w_e = w_e_full[EW-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_LCG1;
            S_LCG1:  n_state = S_GAIN;
            S_GAIN:  n_state = S_LCG2;
            S_LCG2:  n_state = S_TAP_E;
            S_TAP_E: n_state = S_TAP_F;
            S_TAP_F: begin
                if (r_tap == TAPW'(FILTER_TAPS - 1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = S_TAP_E;
                end
            end
            S_WAIT:  n_state = S_ERR;
            S_ERR:   n_state = S_SUB;
            S_SUB:   n_state = S_ROUND;
            S_ROUND: n_state = S_STORE;
            S_STORE: begin
                if (int'(r_ch) == CHANNEL_COUNT - 1) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LCG1;
                end
            end
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state, gain register and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_NONE;
            r_ch        <= 1'b0;
            r_tap       <= '0;
            r_gain      <= GAIN_RESET;
            r_lcg       <= LCG_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (i_cfg.valid) begin
                r_gain <= i_cfg.data;
            end
            if (r_kind == K_LCG1 || r_kind == K_LCG2) begin
                r_lcg <= w_lcg_next;
            end
            if (w_in_take) begin
                r_ch <= 1'b0;
            end else if (r_state == S_STORE) begin
                r_ch <= 1'b1;
            end
            if (r_state == S_LCG2) begin
                r_tap <= '0;
            end else if (r_state == S_TAP_F) begin
                r_tap <= r_tap + 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shaping histories, newest at tap zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                for (int j = 0; j < FILTER_TAPS; j++) begin
                    r_fh[c][j] <= '0;
                    r_eh[c][j] <= '0;
                end
            end
        end else if (r_state == S_STORE) begin
            for (int j = FILTER_TAPS - 1; j > 0; j--) begin
                r_fh[w_ch_idx][j] <= r_fh[w_ch_idx][j-1];
                r_eh[w_ch_idx][j] <= r_eh[w_ch_idx][j-1];
            end
            r_fh[w_ch_idx][0] <= r_err;
            r_eh[w_ch_idx][0] <= w_e;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // frame capture
        if (w_in_take) begin
            r_left  <= i_in.left_sample;
            r_right <= i_in.right_sample;
            r_last  <= i_in.block_end;
            r_clip  <= 1'b0;
            r_yr    <= '0;
        end

        // consume the product register
        case (r_kind)
            K_LCG1:  r_u1  <= w_lcg_next;
            K_GAIN:  r_s   <= SW'(w_prod >>> (23 - F));
            K_TAP_E: r_acc <= r_acc + AW'(w_prod);
            K_TAP_F: r_acc <= r_acc - AW'(w_prod);
            default: begin
            end
        endcase
        if (r_state == S_LCG1) begin
            r_acc <= '0;
        end

        // finishing steps of one channel
        if (r_state == S_WAIT) begin
            r_dith <= DW'(w_ud >>> (LCG_W - F));
        end
        if (r_state == S_ERR) begin
            r_err <= w_err;
            r_sr  <= VW'(r_s) + VW'(r_dith);
        end
        if (r_state == S_SUB) begin
            r_sp <= VW'(r_s) - VW'(r_err);
            r_v  <= r_sr - VW'(r_err);
        end
        if (r_state == S_ROUND) begin
            r_y <= w_y;
            if (w_sat) begin
                r_clip <= 1'b1;
            end
        end
        if (r_state == S_STORE) begin
            if (r_ch == 1'b0) begin
                r_yl <= r_y;
            end else begin
                r_yr <= r_y;
            end
        end

        // result register
        if (r_state == S_DONE && w_out_free) begin
            r_out_left  <= r_yl;
            r_out_right <= r_yr;
            r_out_clip  <= r_clip;
            r_out_last  <= r_last;
        end
    end

endmodule

[verif/nsdq_tb_pkg.sv]
`timescale 1ns / 100ps

package nsdq_tb_pkg;
    import nsdq_pkg::*;

    // one output frame as seen on the result channel
    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    clipped;
        logic                    last;
    } t_frame_result;

    // shaping taps in q.12, rounded half away from zero
    localparam longint ERR_TAP [0:3] = '{9036, -1928, -1038, -2545};
    localparam longint OUT_TAP [0:3] = '{4336, 277, -2480, -1121};
    localparam int     FRAC     = 12;
    localparam longint HALF_LSB = 2048;
    localparam longint ERR_LIM  = 6144;

    class requant_scoreboard;
        longint        qerr_hist [2][4];
        longint        fout_hist [2][4];
        bit [LCG_W-1:0] lcg;
        longint        gain;
        t_frame_result expected_frames [$];
        int            mismatches;

        function new();
            foreach (qerr_hist[c, j]) begin
                qerr_hist[c][j] = 0;
                fout_hist[c][j] = 0;
            end
            lcg        = LCG_SEED;
            gain       = longint'(GAIN_RESET);
            mismatches = 0;
        endfunction

        function void set_gain(bit [GAIN_W-1:0] g);
            gain = longint'(g);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function bit [LCG_W-1:0] next_draw();
            lcg = lcg * LCG_MUL + LCG_INC;
            return lcg;
        endfunction

        // one channel through gain, shaping filter, dither and rounding
        function longint requantize_channel(int ch, longint sample, inout bit clip);
            longint s;
            longint acc;
            longint err;
            longint u1;
            longint u2;
            longint v;
            longint mag;
            longint y;
            longint e;
            s   = (sample * gain) >>> (23 - FRAC);
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                acc += ERR_TAP[j] * qerr_hist[ch][j];
                acc -= OUT_TAP[j] * fout_hist[ch][j];
            end
            err = (acc + HALF_LSB) >>> FRAC;
            if (err > HIST_MAX) err = HIST_MAX;
            if (err < HIST_MIN) err = HIST_MIN;

            // age both histories, newest at tap 0
            for (int j = 3; j > 0; j--) begin
                fout_hist[ch][j] = fout_hist[ch][j-1];
                qerr_hist[ch][j] = qerr_hist[ch][j-1];
            end
            fout_hist[ch][0] = err;

            // triangular dither from two chained draws
            s  -= err;
            u1  = next_draw();
            u2  = next_draw();
            v   = s + ((u1 - u2) >>> (32 - FRAC));

            // round half away from zero, then saturate
            mag = (v < 0) ? -v : v;
            mag = (mag + HALF_LSB) >>> FRAC;
            y   = (v < 0) ? -mag : mag;
            if (y > OUT_POS_MAX) begin
                y    = OUT_POS_MAX;
                clip = 1'b1;
            end else if (y < -longint'(OUT_NEG_MAG)) begin
                y    = -longint'(OUT_NEG_MAG);
                clip = 1'b1;
            end

            e = y * (longint'(1) << FRAC) - s;
            if (e > ERR_LIM)  e = ERR_LIM;
            if (e < -ERR_LIM) e = -ERR_LIM;
            qerr_hist[ch][0] = e;
            return y;
        endfunction

        // accepted input transaction: work out the frame it must give
        function void note_frame(logic signed [SAMPLE_W-1:0] l,
                                 logic signed [SAMPLE_W-1:0] r, logic be);
            t_frame_result fr;
            bit            clip;
            clip       = 1'b0;
            fr.left    = 16'(requantize_channel(0, longint'(l), clip));
            fr.right   = 16'(requantize_channel(1, longint'(r), clip));
            fr.clipped = clip;
            fr.last    = be;
            expected_frames.push_back(fr);
        endfunction

        // accepted output transaction against the oldest expected frame
        function void check_frame(t_frame_result got);
            t_frame_result want;
            if (expected_frames.size() == 0) begin
                $error("output frame with none expected: left %0d right %0d",
                       got.left, got.right);
                mismatches++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.left !== want.left) begin
                $error("left_out: expected %0d, got %0d", want.left, got.left);
                mismatches++;
            end
            if (got.right !== want.right) begin
                $error("right_out: expected %0d, got %0d", want.right, got.right);
                mismatches++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last_out: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import nsdq_pkg::*;
    import nsdq_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int BLOCK_LATENCY = 40;
    localparam int PHASE_FRAMES  = 125;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    logic i_clk;
    logic i_rst_n;

    nsdq_cfg_if cfg_bus ();
    nsdq_in_if  frame_in ();
    nsdq_out_if frame_out ();

    noise_shaped_dither_quantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (frame_in),
        .o_out   (frame_out)
    );

    requant_scoreboard board;
    bit                steady;
    int unsigned       cycle_count;
    int                stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 3);
        if (r < 19) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sample with a random magnitude range, extremes included
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        int w;
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: w = $urandom_range(1, 12);
            default: w = $urandom_range(1, 24);
        endcase
        v = SAMPLE_W'($urandom);
        v = v << (SAMPLE_W - w);
        v = v >>> (SAMPLE_W - w);
        return v;
    endfunction

    // result side: accept and check, then choose ready for the next edge
    initial begin
        frame_out.ready = 1'b0;
        stall_left      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && frame_out.valid && frame_out.ready)
                board.check_frame('{frame_out.left_out, frame_out.right_out,
                                    frame_out.clipped, frame_out.last_out});
            @(negedge i_clk);
            if (steady) begin
                frame_out.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                frame_out.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                frame_out.ready <= 1'b0;
            end else begin
                frame_out.ready <= 1'b1;
            end
        end
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_frame(logic signed [SAMPLE_W-1:0] l,
                              logic signed [SAMPLE_W-1:0] r, logic be);
        int gap;
        gap = (steady || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap > 0) begin
            frame_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        frame_in.valid        <= 1'b1;
        frame_in.left_sample  <= l;
        frame_in.right_sample <= r;
        frame_in.block_end    <= be;
        do @(posedge i_clk); while (!frame_in.ready);
        board.note_frame(l, r, be);
        @(negedge i_clk);
    endtask

    // let every expected frame come back, then let the block settle
    task automatic drain();
        frame_in.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (BLOCK_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_gain(bit [GAIN_W-1:0] g);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= g;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.set_gain(g);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // blocks of random length closed by block_end, some with a stray or a missing marker
    task automatic run_blocks(int count);
        int sent;
        int len;
        logic be;
        sent = 0;
        while (sent < count) begin
            len    = $urandom_range(1, 16);
            steady = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++) begin
                be = (k == len - 1);
                if ($urandom_range(0, 9) == 0) be = 1'($urandom_range(0, 1));
                send_frame(pick_sample(), pick_sample(), be);
            end
            sent += len;
        end
        steady = 1'b0;
    endtask

    // stimulus
    initial begin
        bit [GAIN_W-1:0] gains [7];
        board                 = new();
        steady                = 1'b0;
        i_rst_n               = 1'b0;
        frame_in.valid        = 1'b0;
        frame_in.left_sample  = '0;
        frame_in.right_sample = '0;
        frame_in.block_end    = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.data          = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at the reset gain
        send_frame('0, '0, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(-24'sd1, 24'sd1, 1'b1);
        send_frame(24'sh555555, 24'shAAAAAA, 1'b0);
        // held full scale and alternating extremes push the output into clipping
        for (int k = 0; k < 4; k++) send_frame(SAMPLE_MAX, SAMPLE_MAX, k == 3);
        for (int k = 0; k < 4; k++) send_frame(SAMPLE_MIN, SAMPLE_MIN, k == 3);
        for (int k = 0; k < 4; k++)
            send_frame(k[0] ? SAMPLE_MIN : SAMPLE_MAX, k[0] ? SAMPLE_MAX : SAMPLE_MIN,
                       k == 3);
        drain();

        // top gain with the extremes
        write_gain(15'd32767);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        drain();

        // random phases over a range of gains
        gains = '{15'd0, 15'd1, 15'd32767, 15'($urandom), 15'($urandom),
                  15'd16384, GAIN_RESET};
        foreach (gains[p]) begin
            write_gain(gains[p]);
            run_blocks(PHASE_FRAMES);
            drain();
        end

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
